>>> src/rti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_pkg
// Shared widths, register indexes, payload structs and small helpers for the
// ray/triangle intersection pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

  // Vertex coordinate width, signed Q(CW-10).10
  localparam int CW = 20;
  // Ray origin and direction width, signed Q10.10
  localparam int RW = 20;
  // Distance window width, signed Q16.16
  localparam int TDW = 32;
  // Texture coordinate width, signed Q4.12
  localparam int UVW = 16;
  // Barycentric weight width, Q1.16
  localparam int WW = 17;
  // Fraction bits of the distance and the weights
  localparam int FB = 16;

  // Intermediate vector widths
  localparam int EW  = CW + 1;
  localparam int SW  = ((CW > RW) ? CW : RW) + 1;
  localparam int HW  = RW + EW + 1;
  localparam int AW  = 64;
  localparam int QW0 = SW + EW + 1;
  localparam int QW  = (QW0 > AW) ? AW : QW0;

  // Divider: quotient bits per lane, signed distance width after sign fix
  localparam int DVW = 33;
  localparam int TW  = DVW + 2;

  // Configuration port
  localparam int VREG_W  = 60;
  localparam int UVREG_W = 32;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 60;

  localparam logic [CFG_IW-1:0] REG_VERTEX0  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_VERTEX1  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_VERTEX2  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_TEXCOORD0 = 3'd3;
  localparam logic [CFG_IW-1:0] REG_TEXCOORD1 = 3'd4;
  localparam logic [CFG_IW-1:0] REG_TEXCOORD2 = 3'd5;

  typedef struct packed {
    logic [VREG_W-1:0]  v0;
    logic [VREG_W-1:0]  v1;
    logic [VREG_W-1:0]  v2;
    logic [UVREG_W-1:0] uv0;
    logic [UVREG_W-1:0] uv1;
    logic [UVREG_W-1:0] uv2;
  } cfg_t;

  // Per-ray sideband that travels with the arithmetic
  typedef struct packed {
    logic                  valid;
    logic                  miss;
    logic                  ff;
    logic                  sneg;
    logic signed [RW-1:0]  ox;
    logic signed [RW-1:0]  oy;
    logic signed [RW-1:0]  oz;
    logic signed [RW-1:0]  dx;
    logic signed [RW-1:0]  dy;
    logic signed [RW-1:0]  dz;
    logic signed [TDW-1:0] tn;
    logic signed [TDW-1:0] tf;
  } side_t;

  // Front end to divider: positive determinant and the three dividends
  typedef struct packed {
    side_t         side;
    logic [AW-1:0] den;
    logic [AW-1:0] num_t;
    logic [AW-1:0] num_u;
    logic [AW-1:0] num_v;
  } front_t;

  typedef struct packed {
    logic                  hit;
    logic signed [TDW-1:0] hit_t;
    logic signed [RW-1:0]  point_x;
    logic signed [RW-1:0]  point_y;
    logic signed [RW-1:0]  point_z;
    logic signed [UVW-1:0] tex_u;
    logic signed [UVW-1:0] tex_v;
    logic [WW-1:0]         weight_one;
    logic [WW-1:0]         weight_two;
    logic                  front_facing;
  } result_t;

  // Pick coordinate k of a packed vertex register; bits past the register read 0
  function automatic logic signed [CW-1:0] get_coord(input logic [VREG_W-1:0] r,
                                                     input int k);
    logic [3*CW+VREG_W-1:0] ext;
    ext = (3*CW+VREG_W)'(r);
    return ext[k*CW +: CW];
  endfunction

  // Saturate a hit point sum to the ray coordinate width
  function automatic logic signed [RW-1:0] sat_coord(input logic signed [RW+16:0] x);
    logic in_range;
    in_range = (x[RW+16:RW-1] == '0) || (x[RW+16:RW-1] == '1);
    if (in_range) begin
      return x[RW-1:0];
    end else if (x[RW+16]) begin
      return {1'b1, {(RW-1){1'b0}}};
    end else begin
      return {1'b0, {(RW-1){1'b1}}};
    end
  endfunction

  // Saturate an interpolated texture sum to the texture coordinate width
  function automatic logic signed [UVW-1:0] sat_tex(input logic signed [UVW+4:0] x);
    logic in_range;
    in_range = (x[UVW+4:UVW-1] == '0) || (x[UVW+4:UVW-1] == '1);
    if (in_range) begin
      return x[UVW-1:0];
    end else if (x[UVW+4]) begin
      return {1'b1, {(UVW-1){1'b0}}};
    end else begin
      return {1'b0, {(UVW-1){1'b1}}};
    end
  endfunction

endpackage

>>> src/ray_triangle_intersect_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top
// Fixed-point ray/triangle hit test against one triangle held in registers.
// ----------------------------------------------------------------------------
// Takes one ray word per clock while ray_stall is low and returns one result
// word per ray, in order. An accepted ray passes eight stages of vector
// arithmetic, a 34-stage divider (one setup stage and one quotient bit per
// stage for the 33-bit distance quotient), two stages for the window test
// and the hit-point/texture products, and the output buffer. Throughput is
// one ray per cycle while ray_stall is low. A two-word output buffer lets
// the pipeline keep accepting while a result waits; ray_stall rises only
// when that buffer is full. Write the triangle and texture registers only
// while no ray is in flight; no clearing pass follows reset.
module ray_triangle_intersect_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rti_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [rti_pkg::CFG_DW-1:0]         cfg_data,
  input  logic                               ray_valid,
  output logic                               ray_stall,
  input  logic signed [rti_pkg::RW-1:0]      origin_x,
  input  logic signed [rti_pkg::RW-1:0]      origin_y,
  input  logic signed [rti_pkg::RW-1:0]      origin_z,
  input  logic signed [rti_pkg::RW-1:0]      dir_x,
  input  logic signed [rti_pkg::RW-1:0]      dir_y,
  input  logic signed [rti_pkg::RW-1:0]      dir_z,
  input  logic signed [rti_pkg::TDW-1:0]     t_near,
  input  logic signed [rti_pkg::TDW-1:0]     t_far,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic                               hit,
  output logic signed [rti_pkg::TDW-1:0]     hit_t,
  output logic signed [rti_pkg::RW-1:0]      point_x,
  output logic signed [rti_pkg::RW-1:0]      point_y,
  output logic signed [rti_pkg::RW-1:0]      point_z,
  output logic signed [rti_pkg::UVW-1:0]     tex_u,
  output logic signed [rti_pkg::UVW-1:0]     tex_v,
  output logic [rti_pkg::WW-1:0]             weight_one,
  output logic [rti_pkg::WW-1:0]             weight_two,
  output logic                               front_facing
);

  rti_pkg::cfg_t    cfg;
  rti_pkg::front_t  front;
  rti_pkg::side_t   div_side;
  rti_pkg::result_t result;
  logic [rti_pkg::DVW-1:0] quo [3];
  logic             inexact;
  logic             adv;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rti_pkg::REG_VERTEX0:   cfg.v0  <= cfg_data[rti_pkg::VREG_W-1:0];
        rti_pkg::REG_VERTEX1:   cfg.v1  <= cfg_data[rti_pkg::VREG_W-1:0];
        rti_pkg::REG_VERTEX2:   cfg.v2  <= cfg_data[rti_pkg::VREG_W-1:0];
        rti_pkg::REG_TEXCOORD0: cfg.uv0 <= cfg_data[rti_pkg::UVREG_W-1:0];
        rti_pkg::REG_TEXCOORD1: cfg.uv1 <= cfg_data[rti_pkg::UVREG_W-1:0];
        rti_pkg::REG_TEXCOORD2: cfg.uv2 <= cfg_data[rti_pkg::UVREG_W-1:0];
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  assign ray_stall = !adv;

  rti_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (ray_valid),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .origin_z (origin_z),
    .dir_x    (dir_x),
    .dir_y    (dir_y),
    .dir_z    (dir_z),
    .t_near   (t_near),
    .t_far    (t_far),
    .cfg      (cfg),
    .front    (front)
  );

  rti_div u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .front    (front),
    .side_out (div_side),
    .quo      (quo),
    .inexact  (inexact)
  );

  rti_back u_back (
    .clk          (clk),
    .rst          (rst),
    .side_in      (div_side),
    .quo          (quo),
    .inexact      (inexact),
    .cfg          (cfg),
    .result_stall (result_stall),
    .adv          (adv),
    .result_valid (result_valid),
    .result       (result)
  );

  assign hit          = result.hit;
  assign hit_t        = result.hit_t;
  assign point_x      = result.point_x;
  assign point_y      = result.point_y;
  assign point_z      = result.point_z;
  assign tex_u        = result.tex_u;
  assign tex_v        = result.tex_v;
  assign weight_one   = result.weight_one;
  assign weight_two   = result.weight_two;
  assign front_facing = result.front_facing;

endmodule

>>> src/rti_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_front
// Vector part of the test: edges, the two cross products, the four dot
// products, sign fix of the determinant and the barycentric range checks.
// Eight register stages, all advancing together on adv.
// ----------------------------------------------------------------------------
module rti_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           in_valid,
  input  logic signed [rti_pkg::RW-1:0]  origin_x,
  input  logic signed [rti_pkg::RW-1:0]  origin_y,
  input  logic signed [rti_pkg::RW-1:0]  origin_z,
  input  logic signed [rti_pkg::RW-1:0]  dir_x,
  input  logic signed [rti_pkg::RW-1:0]  dir_y,
  input  logic signed [rti_pkg::RW-1:0]  dir_z,
  input  logic signed [rti_pkg::TDW-1:0] t_near,
  input  logic signed [rti_pkg::TDW-1:0] t_far,
  input  rti_pkg::cfg_t                  cfg,
  output rti_pkg::front_t                front
);

  localparam int RW = rti_pkg::RW;
  localparam int CW = rti_pkg::CW;
  localparam int EW = rti_pkg::EW;
  localparam int SW = rti_pkg::SW;
  localparam int HW = rti_pkg::HW;
  localparam int QW = rti_pkg::QW;
  localparam int AW = rti_pkg::AW;

  rti_pkg::side_t side1, side2, side3, side4, side5, side6, side7, side8;
  rti_pkg::side_t side7_next, side8_next;

  logic signed [CW-1:0] p0 [3];
  logic signed [CW-1:0] p1 [3];
  logic signed [CW-1:0] p2 [3];
  logic signed [EW-1:0] e1c [3];
  logic signed [EW-1:0] e2c [3];

  logic signed [RW-1:0] dv1 [3];
  logic signed [RW-1:0] ov1 [3];

  logic signed [RW-1:0] dv2 [3];
  logic signed [SW-1:0] s2  [3];
  logic signed [EW-1:0] e1_2 [3];
  logic signed [EW-1:0] e2_2 [3];

  logic signed [RW+EW-1:0] hpa [3];
  logic signed [RW+EW-1:0] hpb [3];
  logic signed [SW+EW-1:0] qpa [3];
  logic signed [SW+EW-1:0] qpb [3];
  logic signed [RW-1:0]    dv3 [3];
  logic signed [SW-1:0]    s3  [3];
  logic signed [EW-1:0]    e1_3 [3];
  logic signed [EW-1:0]    e2_3 [3];

  logic signed [HW-1:0] h4 [3];
  logic signed [QW-1:0] q4 [3];
  logic signed [RW-1:0] dv4 [3];
  logic signed [SW-1:0] s4  [3];
  logic signed [EW-1:0] e1_4 [3];
  logic signed [EW-1:0] e2_4 [3];

  logic signed [EW+HW-1:0] ma [3];
  logic signed [SW+HW-1:0] mu [3];
  logic signed [RW+QW-1:0] mv [3];
  logic signed [EW+QW-1:0] mt [3];

  logic signed [AW-1:0] a6, su6, sv6, st6;
  logic signed [AW-1:0] a7, su7, sv7, st7;
  logic        [AW-1:0] den8, num8, su8, sv8;

  // Triangle corners and edges, straight from the configuration registers
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p0[i]  = rti_pkg::get_coord(cfg.v0, i);
      p1[i]  = rti_pkg::get_coord(cfg.v1, i);
      p2[i]  = rti_pkg::get_coord(cfg.v2, i);
      e1c[i] = EW'(p1[i]) - EW'(p0[i]);
      e2c[i] = EW'(p2[i]) - EW'(p0[i]);
    end
  end

  // Stage 1: capture the ray word
  always_ff @(posedge clk) begin
    if (rst) begin
      side1.valid <= 1'b0;
    end else if (adv) begin
      side1.valid <= in_valid;
      side1.miss  <= 1'b0;
      side1.ff    <= 1'b0;
      side1.sneg  <= 1'b0;
      side1.ox    <= origin_x;
      side1.oy    <= origin_y;
      side1.oz    <= origin_z;
      side1.dx    <= dir_x;
      side1.dy    <= dir_y;
      side1.dz    <= dir_z;
      side1.tn    <= t_near;
      side1.tf    <= t_far;
    end
  end

  assign ov1[0] = side1.ox;
  assign ov1[1] = side1.oy;
  assign ov1[2] = side1.oz;
  assign dv1[0] = side1.dx;
  assign dv1[1] = side1.dy;
  assign dv1[2] = side1.dz;

  // Stage 2: origin relative to the first corner, latch the edges
  always_ff @(posedge clk) begin
    if (rst) begin
      side2.valid <= 1'b0;
    end else if (adv) begin
      side2 <= side1;
      for (int i = 0; i < 3; i++) begin
        s2[i]   <= SW'(ov1[i]) - SW'(p0[i]);
        dv2[i]  <= dv1[i];
        e1_2[i] <= e1c[i];
        e2_2[i] <= e2c[i];
      end
    end
  end

  // Stage 3: partial products of dir x edge2 and s x edge1
  always_ff @(posedge clk) begin
    if (rst) begin
      side3.valid <= 1'b0;
    end else if (adv) begin
      side3  <= side2;
      hpa[0] <= dv2[1] * e2_2[2];
      hpb[0] <= dv2[2] * e2_2[1];
      hpa[1] <= dv2[2] * e2_2[0];
      hpb[1] <= dv2[0] * e2_2[2];
      hpa[2] <= dv2[0] * e2_2[1];
      hpb[2] <= dv2[1] * e2_2[0];
      qpa[0] <= s2[1] * e1_2[2];
      qpb[0] <= s2[2] * e1_2[1];
      qpa[1] <= s2[2] * e1_2[0];
      qpb[1] <= s2[0] * e1_2[2];
      qpa[2] <= s2[0] * e1_2[1];
      qpb[2] <= s2[1] * e1_2[0];
      for (int i = 0; i < 3; i++) begin
        dv3[i]  <= dv2[i];
        s3[i]   <= s2[i];
        e1_3[i] <= e1_2[i];
        e2_3[i] <= e2_2[i];
      end
    end
  end

  // Stage 4: finish the cross products h and q
  always_ff @(posedge clk) begin
    if (rst) begin
      side4.valid <= 1'b0;
    end else if (adv) begin
      side4 <= side3;
      for (int i = 0; i < 3; i++) begin
        h4[i]   <= HW'(hpa[i]) - HW'(hpb[i]);
        q4[i]   <= QW'(qpa[i]) - QW'(qpb[i]);
        dv4[i]  <= dv3[i];
        s4[i]   <= s3[i];
        e1_4[i] <= e1_3[i];
        e2_4[i] <= e2_3[i];
      end
    end
  end

  // Stage 5: terms of the four dot products
  always_ff @(posedge clk) begin
    if (rst) begin
      side5.valid <= 1'b0;
    end else if (adv) begin
      side5 <= side4;
      for (int i = 0; i < 3; i++) begin
        ma[i] <= e1_4[i] * h4[i];
        mu[i] <= s4[i] * h4[i];
        mv[i] <= dv4[i] * q4[i];
        mt[i] <= e2_4[i] * q4[i];
      end
    end
  end

  // Stage 6: sum the terms, wrapping at the accumulator width
  always_ff @(posedge clk) begin
    if (rst) begin
      side6.valid <= 1'b0;
    end else if (adv) begin
      side6 <= side5;
      a6    <= AW'(ma[0]) + AW'(ma[1]) + AW'(ma[2]);
      su6   <= AW'(mu[0]) + AW'(mu[1]) + AW'(mu[2]);
      sv6   <= AW'(mv[0]) + AW'(mv[1]) + AW'(mv[2]);
      st6   <= AW'(mt[0]) + AW'(mt[1]) + AW'(mt[2]);
    end
  end

  // Facing and zero determinant for stage 7
  always_comb begin
    side7_next      = side6;
    side7_next.ff   = (a6 > 0);
    side7_next.miss = side6.miss | (a6 == '0);
  end

  // Stage 7: flip everything to a positive determinant
  always_ff @(posedge clk) begin
    if (rst) begin
      side7.valid <= 1'b0;
    end else if (adv) begin
      side7 <= side7_next;
      a7  <= a6[AW-1] ? -a6  : a6;
      su7 <= a6[AW-1] ? -su6 : su6;
      sv7 <= a6[AW-1] ? -sv6 : sv6;
      st7 <= a6[AW-1] ? -st6 : st6;
    end
  end

  // Barycentric range checks and distance sign for stage 8
  always_comb begin
    side8_next      = side7;
    side8_next.miss = side7.miss | (a7 <= 0) | su7[AW-1] | (su7 > a7) |
                      sv7[AW-1] | (sv7 > (a7 - su7));
    side8_next.sneg = st7[AW-1];
  end

  // Stage 8: magnitude of the distance numerator
  always_ff @(posedge clk) begin
    if (rst) begin
      side8.valid <= 1'b0;
    end else if (adv) begin
      side8 <= side8_next;
      den8  <= a7;
      num8  <= st7[AW-1] ? -st7 : st7;
      su8   <= su7;
      sv8   <= sv7;
    end
  end

  assign front.side  = side8;
  assign front.den   = den8;
  assign front.num_t = num8;
  assign front.num_u = su8;
  assign front.num_v = sv8;

endmodule

>>> src/rti_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring divider, three lanes sharing one divisor. Each lane
// forms floor(num * 2^16 / den) one quotient bit per stage; lane 0 also
// reports overflow of the quotient range and a nonzero remainder.
// ----------------------------------------------------------------------------
module rti_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  rti_pkg::front_t         front,
  output rti_pkg::side_t          side_out,
  output logic [rti_pkg::DVW-1:0] quo [3],
  output logic                    inexact
);

  localparam int AW  = rti_pkg::AW;
  localparam int DVW = rti_pkg::DVW;
  localparam int FB  = rti_pkg::FB;

  rti_pkg::side_t  sd [DVW+1];
  rti_pkg::side_t  sd0_next;
  logic [AW-1:0]   dn [DVW+1];
  logic [AW-1:0]   pr [3][DVW+1];
  logic [DVW-1:0]  xq [3][DVW+1];
  logic [AW-1:0]   num [3];
  logic            ovf;

  assign num[0] = front.num_t;
  assign num[1] = front.num_u;
  assign num[2] = front.num_v;

  // Quotient too wide for the distance range: the ray cannot hit
  assign ovf = (front.num_t >> (DVW - FB)) >= front.den;

  // Fold the overflow into the sideband
  always_comb begin
    sd0_next      = front.side;
    sd0_next.miss = front.side.miss | ovf;
  end

  // Setup: split each scaled dividend into the starting remainder and the bits to shift in
  always_ff @(posedge clk) begin
    if (rst) begin
      sd[0].valid <= 1'b0;
    end else if (adv) begin
      sd[0] <= sd0_next;
      dn[0] <= front.den;
      for (int l = 0; l < 3; l++) begin
        pr[l][0] <= num[l] >> (DVW - FB);
        xq[l][0] <= DVW'({num[l], {FB{1'b0}}});
      end
    end
  end

  // One quotient bit per stage and lane
  for (genvar k = 1; k <= DVW; k++) begin : g_stage
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [AW:0] trial;
      logic        ge;

      assign trial = {pr[l][k-1], xq[l][k-1][DVW-1]};
      assign ge    = trial >= {1'b0, dn[k-1]};

      always_ff @(posedge clk) begin
        if (adv) begin
          pr[l][k] <= ge ? AW'(trial - {1'b0, dn[k-1]}) : trial[AW-1:0];
          xq[l][k] <= {xq[l][k-1][DVW-2:0], ge};
        end
      end
    end

    // Advance the sideband and the divisor alongside
    always_ff @(posedge clk) begin
      if (rst) begin
        sd[k].valid <= 1'b0;
      end else if (adv) begin
        sd[k] <= sd[k-1];
        dn[k] <= dn[k-1];
      end
    end
  end

  assign side_out = sd[DVW];
  assign quo[0]   = xq[0][DVW];
  assign quo[1]   = xq[1][DVW];
  assign quo[2]   = xq[2][DVW];
  assign inexact  = (pr[0][DVW] != '0);

endmodule

>>> src/rti_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_back
// Signed distance, window test, hit point and texture interpolation, then a
// two-word output buffer that decouples the pipeline from the result stall.
// ----------------------------------------------------------------------------
module rti_back (
  input  logic                    clk,
  input  logic                    rst,
  input  rti_pkg::side_t          side_in,
  input  logic [rti_pkg::DVW-1:0] quo [3],
  input  logic                    inexact,
  input  rti_pkg::cfg_t           cfg,
  input  logic                    result_stall,
  output logic                    adv,
  output logic                    result_valid,
  output rti_pkg::result_t        result
);

  localparam int RW  = rti_pkg::RW;
  localparam int TW  = rti_pkg::TW;
  localparam int TDW = rti_pkg::TDW;
  localparam int UVW = rti_pkg::UVW;
  localparam int WW  = rti_pkg::WW;
  localparam int FB  = rti_pkg::FB;
  localparam int MW  = WW + UVW + 2;

  rti_pkg::side_t sa, sb, sb_next;
  logic signed [TW-1:0]      ta;
  logic signed [TDW-1:0]     t32a;
  logic signed [TDW-1:0]     tb;
  logic [WW-1:0]             wa1, wa2, wb1, wb2;
  logic                      inexa;
  logic                      hit_b;

  logic signed [UVW-1:0]     uv0u, uv0v, uv1u, uv1v, uv2u, uv2v;
  logic signed [UVW:0]       du1, du2, dv1, dv2;
  logic signed [RW+TDW-1:0]  mpx, mpy, mpz;
  logic signed [MW-1:0]      mu1, mu2, mv1, mv2;
  logic signed [UVW-1:0]     uvb_u, uvb_v;

  logic signed [RW+16:0]     px_sum, py_sum, pz_sum;
  logic signed [MW:0]        acc_u, acc_v;
  logic signed [UVW+4:0]     tu_sum, tv_sum;
  rti_pkg::result_t          res_c;

  rti_pkg::result_t          b0, b1;
  logic [1:0]                count;
  logic                      push, pop;

  // Texture differences, straight from the configuration registers
  assign uv0u = cfg.uv0[UVW-1:0];
  assign uv0v = cfg.uv0[2*UVW-1:UVW];
  assign uv1u = cfg.uv1[UVW-1:0];
  assign uv1v = cfg.uv1[2*UVW-1:UVW];
  assign uv2u = cfg.uv2[UVW-1:0];
  assign uv2v = cfg.uv2[2*UVW-1:UVW];
  assign du1  = (UVW+1)'(uv1u) - (UVW+1)'(uv0u);
  assign du2  = (UVW+1)'(uv2u) - (UVW+1)'(uv0u);
  assign dv1  = (UVW+1)'(uv1v) - (UVW+1)'(uv0v);
  assign dv2  = (UVW+1)'(uv2v) - (UVW+1)'(uv0v);

  // Stage A: apply the numerator sign, floor toward minus infinity
  always_ff @(posedge clk) begin
    if (rst) begin
      sa.valid <= 1'b0;
    end else if (adv) begin
      sa    <= side_in;
      ta    <= side_in.sneg ? (-TW'(quo[0]) - TW'(inexact)) : TW'(quo[0]);
      inexa <= inexact;
      wa1   <= quo[1][WW-1:0];
      wa2   <= quo[2][WW-1:0];
    end
  end

  assign t32a  = ta[TDW-1:0];
  assign hit_b = !sa.miss && !(ta < TW'(sa.tn)) && !(ta > TW'(sa.tf)) &&
                 !((ta == TW'(sa.tf)) && inexa);

  // Window test result for stage B
  always_comb begin
    sb_next      = sa;
    sb_next.miss = !hit_b;
  end

  // Stage B: products for the hit point and the texture blend
  always_ff @(posedge clk) begin
    if (rst) begin
      sb.valid <= 1'b0;
    end else if (adv) begin
      sb      <= sb_next;
      tb      <= t32a;
      wb1     <= wa1;
      wb2     <= wa2;
      mpx     <= sa.dx * t32a;
      mpy     <= sa.dy * t32a;
      mpz     <= sa.dz * t32a;
      mu1     <= $signed({1'b0, wa1}) * du1;
      mu2     <= $signed({1'b0, wa2}) * du2;
      mv1     <= $signed({1'b0, wa1}) * dv1;
      mv2     <= $signed({1'b0, wa2}) * dv2;
      uvb_u   <= uv0u;
      uvb_v   <= uv0v;
    end
  end

  // Final sums with saturation; a miss gives an all-zero word
  always_comb begin
    px_sum = (RW+17)'(sb.ox) + (RW+17)'(mpx >>> FB);
    py_sum = (RW+17)'(sb.oy) + (RW+17)'(mpy >>> FB);
    pz_sum = (RW+17)'(sb.oz) + (RW+17)'(mpz >>> FB);
    acc_u  = (MW+1)'(mu1) + (MW+1)'(mu2);
    acc_v  = (MW+1)'(mv1) + (MW+1)'(mv2);
    tu_sum = (UVW+5)'(acc_u >>> FB) + (UVW+5)'(uvb_u);
    tv_sum = (UVW+5)'(acc_v >>> FB) + (UVW+5)'(uvb_v);
    res_c  = '0;
    if (!sb.miss) begin
      res_c.hit          = 1'b1;
      res_c.hit_t        = tb;
      res_c.point_x      = rti_pkg::sat_coord(px_sum);
      res_c.point_y      = rti_pkg::sat_coord(py_sum);
      res_c.point_z      = rti_pkg::sat_coord(pz_sum);
      res_c.tex_u        = rti_pkg::sat_tex(tu_sum);
      res_c.tex_v        = rti_pkg::sat_tex(tv_sum);
      res_c.weight_one   = wb1;
      res_c.weight_two   = wb2;
      res_c.front_facing = sb.ff;
    end
  end

  // Output buffer: two words, the pipeline holds only when both are taken
  assign adv          = (count != 2'd2);
  assign push         = adv && sb.valid;
  assign result_valid = (count != 2'd0);
  assign pop          = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10: begin
          count <= count + 2'd1;
        end
        2'b01: begin
          count <= count - 2'd1;
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          b0 <= res_c;
        end else begin
          b1 <= res_c;
        end
      end
      2'b01: begin
        b0 <= b1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          b0 <= res_c;
        end else begin
          b0 <= b1;
          b1 <= res_c;
        end
      end
      default: begin
        b0 <= b0;
      end
    endcase
  end

  assign result = b0;

endmodule
